FILE: design/stq_pkg.sv
// Shared constants for the sorted timer expiry queue.
// No dependencies; imported by sorted_timer_expiry_queue_unit.
`default_nettype none
package stq_pkg;
   localparam int ID_W      = 5;
   localparam int IN_TIME_W = 32;

   localparam logic [1:0] ACT_ADD    = 2'd0;
   localparam logic [1:0] ACT_ADJUST = 2'd1;
   localparam logic [1:0] ACT_DELETE = 2'd2;
   localparam logic [1:0] ACT_TICK   = 2'd3;

   localparam logic [1:0] STS_OK     = 2'd0;
   localparam logic [1:0] STS_FULL   = 2'd1;
   localparam logic [1:0] STS_ABSENT = 2'd2;
   localparam logic [1:0] STS_DUP    = 2'd3;
endpackage
`default_nettype wire

FILE: design/stq_mem.sv
// Single-port-write, single-port-read entry memory with registered read data.
// Depends on nothing; used by sorted_timer_expiry_queue_unit.
`default_nettype none
module stq_mem #(
   parameter int DEPTH = 32,
   parameter int WIDTH = 37,
   parameter int ADDR_W = 5
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

FILE: design/sorted_timer_expiry_queue_unit.sv
// Top level of the sorted timer expiry queue: sequencer around the entry memory.
// Depends on stq_pkg and stq_mem.
//
//   channel | direction | handshake               | payload
//   req     | in        | req_valid / req_stall   | action, timer_id, expire_time, now_time
//   rsp     | out       | rsp_valid / rsp_stall   | expired_id, expired_flag, last, status
//
// One request at a time. Each walk moves one stored entry per cycle through the memory's
// single read and write port while it is not held. Rejected requests go straight to the
// response state.
// Synchronous reset empties the queue at once; the memory needs no clearing.
// A stalled result holds in the output register; a tick walk holds while an earlier
// expired id still waits there.
`default_nettype none
module sorted_timer_expiry_queue_unit
   import stq_pkg::*;
#(
   parameter int TIMERS    = 32,
   parameter int TIME_BITS = 32
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire logic [1:0]           req_action,
   input  wire logic [ID_W-1:0]      req_timer_id,
   input  wire logic [IN_TIME_W-1:0] req_expire_time,
   input  wire logic [IN_TIME_W-1:0] req_now_time,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output logic [ID_W-1:0]           rsp_expired_id,
   output logic                      rsp_expired_flag,
   output logic                      rsp_last,
   output logic [1:0]                rsp_status
);
   localparam int IDX_W = $clog2(TIMERS);
   localparam int CNT_W = $clog2(TIMERS + 1);
   localparam int ENT_W = ID_W + TIME_BITS;
   localparam int NIDS  = 1 << ID_W;

   localparam logic [2:0] ST_IDLE      = 3'd0;
   localparam logic [2:0] ST_DEL       = 3'd1;
   localparam logic [2:0] ST_INS_START = 3'd2;
   localparam logic [2:0] ST_INS       = 3'd3;
   localparam logic [2:0] ST_PUT       = 3'd4;
   localparam logic [2:0] ST_TICK      = 3'd5;
   localparam logic [2:0] ST_RSP       = 3'd6;

   logic [2:0]           state_ff, state_in;
   logic [1:0]           op_ff, op_in;
   logic [ID_W-1:0]      id_ff, id_in;
   logic [TIME_BITS-1:0] time_ff, time_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [NIDS-1:0]      present_ff, present_in;
   logic [IDX_W-1:0]     idx_ff, idx_in;
   logic [CNT_W-1:0]     k_ff, k_in;
   logic                 found_ff, found_in;
   logic                 pend_valid_ff, pend_valid_in;
   logic [ID_W-1:0]      pend_id_ff, pend_id_in;
   logic [1:0]           status_ff, status_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [ID_W-1:0]      rsp_id_ff, rsp_id_in;
   logic                 rsp_flag_ff, rsp_flag_in;
   logic                 rsp_last_ff, rsp_last_in;
   logic [1:0]           rsp_status_ff, rsp_status_in;

   logic                 rd_en, wr_en;
   logic [IDX_W-1:0]     rd_addr, wr_addr;
   logic [ENT_W-1:0]     wr_data, rd_data;
   logic [ID_W-1:0]      rd_id;
   logic [TIME_BITS-1:0] rd_time;
   logic                 out_free;

   stq_mem #(.DEPTH(TIMERS), .WIDTH(ENT_W), .ADDR_W(IDX_W)) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rd_id    = rd_data[ENT_W-1 -: ID_W];
   assign rd_time  = rd_data[TIME_BITS-1:0];
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      logic             more;
      logic             hold;
      logic [CNT_W-1:0] k_next;
      state_in      = state_ff;
      op_in         = op_ff;
      id_in         = id_ff;
      time_in       = time_ff;
      cnt_in        = cnt_ff;
      present_in    = present_ff;
      idx_in        = idx_ff;
      k_in          = k_ff;
      found_in      = found_ff;
      pend_valid_in = pend_valid_ff;
      pend_id_in    = pend_id_ff;
      status_in     = status_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_id_in     = rsp_id_ff;
      rsp_flag_in   = rsp_flag_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_status_in = rsp_status_ff;
      rd_en         = 1'b0;
      rd_addr       = '0;
      wr_en         = 1'b0;
      wr_addr       = '0;
      wr_data       = '0;
      more          = (CNT_W'(idx_ff) + 1'b1) < cnt_ff;
      hold          = pend_valid_ff && !out_free;
      k_next        = k_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               op_in         = req_action;
               id_in         = req_timer_id;
               time_in       = (req_action == ACT_TICK) ? TIME_BITS'(req_now_time)
                                                        : TIME_BITS'(req_expire_time);
               status_in     = STS_OK;
               k_in          = '0;
               found_in      = 1'b0;
               pend_valid_in = 1'b0;
               idx_in        = '0;
               case (req_action)
                  ACT_ADD: begin
                     if (present_ff[req_timer_id]) begin
                        status_in = STS_DUP;
                        state_in  = ST_RSP;
                     end else if (cnt_ff >= CNT_W'(TIMERS)) begin
                        status_in = STS_FULL;
                        state_in  = ST_RSP;
                     end else begin
                        present_in[req_timer_id] = 1'b1;
                        state_in = ST_INS_START;
                     end
                  end
                  ACT_ADJUST, ACT_DELETE: begin
                     if (!present_ff[req_timer_id]) begin
                        status_in = STS_ABSENT;
                        state_in  = ST_RSP;
                     end else begin
                        rd_en    = 1'b1;
                        state_in = ST_DEL;
                     end
                  end
                  default: begin
                     if (cnt_ff == '0) begin
                        state_in = ST_RSP;
                     end else begin
                        rd_en    = 1'b1;
                        state_in = ST_TICK;
                     end
                  end
               endcase
            end
         end
         ST_DEL: begin
            // close the gap left by the removed entry
            if (found_ff) begin
               wr_en   = 1'b1;
               wr_addr = idx_ff - 1'b1;
               wr_data = rd_data;
            end else if (rd_id == id_ff) begin
               found_in = 1'b1;
            end
            if (more) begin
               rd_en   = 1'b1;
               rd_addr = idx_ff + 1'b1;
               idx_in  = idx_ff + 1'b1;
            end else begin
               cnt_in = cnt_ff - 1'b1;
               if (op_ff == ACT_ADJUST) begin
                  state_in = ST_INS_START;
               end else begin
                  present_in[id_ff] = 1'b0;
                  state_in = ST_RSP;
               end
            end
         end
         ST_INS_START: begin
            if (cnt_ff == '0) begin
               wr_en    = 1'b1;
               wr_addr  = '0;
               wr_data  = {id_ff, time_ff};
               cnt_in   = cnt_ff + 1'b1;
               state_in = ST_RSP;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = IDX_W'(cnt_ff - 1'b1);
               idx_in   = IDX_W'(cnt_ff - 1'b1);
               state_in = ST_INS;
            end
         end
         ST_INS: begin
            // walk from the tail, shifting later entries up one slot
            wr_en   = 1'b1;
            wr_addr = idx_ff + 1'b1;
            if (rd_time > time_ff) begin
               wr_data = rd_data;
               if (idx_ff == '0) begin
                  state_in = ST_PUT;
               end else begin
                  rd_en   = 1'b1;
                  rd_addr = idx_ff - 1'b1;
                  idx_in  = idx_ff - 1'b1;
               end
            end else begin
               wr_data  = {id_ff, time_ff};
               cnt_in   = cnt_ff + 1'b1;
               state_in = ST_RSP;
            end
         end
         ST_PUT: begin
            wr_en    = 1'b1;
            wr_addr  = idx_ff;
            wr_data  = {id_ff, time_ff};
            cnt_in   = cnt_ff + 1'b1;
            state_in = ST_RSP;
         end
         ST_TICK: begin
            if (rd_time <= time_ff) begin
               if (!hold) begin
                  if (pend_valid_ff) begin
                     rsp_valid_in  = 1'b1;
                     rsp_id_in     = pend_id_ff;
                     rsp_flag_in   = 1'b1;
                     rsp_last_in   = 1'b0;
                     rsp_status_in = STS_OK;
                  end
                  pend_id_in        = rd_id;
                  pend_valid_in     = 1'b1;
                  present_in[rd_id] = 1'b0;
                  k_next            = k_ff + 1'b1;
                  k_in              = k_next;
                  if (more) begin
                     rd_en   = 1'b1;
                     rd_addr = idx_ff + 1'b1;
                     idx_in  = idx_ff + 1'b1;
                  end else begin
                     cnt_in   = cnt_ff - k_next;
                     state_in = ST_RSP;
                  end
               end
            end else if (k_ff == '0) begin
               state_in = ST_RSP;
            end else if (!hold) begin
               // first live entry ends the expired run; shift the rest down
               if (pend_valid_ff) begin
                  rsp_valid_in  = 1'b1;
                  rsp_id_in     = pend_id_ff;
                  rsp_flag_in   = 1'b1;
                  rsp_last_in   = 1'b1;
                  rsp_status_in = STS_OK;
               end
               pend_valid_in = 1'b0;
               wr_en   = 1'b1;
               wr_addr = idx_ff - k_ff[IDX_W-1:0];
               wr_data = rd_data;
               if (more) begin
                  rd_en   = 1'b1;
                  rd_addr = idx_ff + 1'b1;
                  idx_in  = idx_ff + 1'b1;
               end else begin
                  cnt_in   = cnt_ff - k_ff;
                  state_in = ST_RSP;
               end
            end
         end
         ST_RSP: begin
            if (pend_valid_ff) begin
               if (out_free) begin
                  rsp_valid_in  = 1'b1;
                  rsp_id_in     = pend_id_ff;
                  rsp_flag_in   = 1'b1;
                  rsp_last_in   = 1'b1;
                  rsp_status_in = STS_OK;
                  pend_valid_in = 1'b0;
                  state_in      = ST_IDLE;
               end
            end else if (op_ff != ACT_TICK || k_ff == '0) begin
               if (out_free) begin
                  rsp_valid_in  = 1'b1;
                  rsp_id_in     = '0;
                  rsp_flag_in   = 1'b0;
                  rsp_last_in   = 1'b1;
                  rsp_status_in = status_ff;
                  state_in      = ST_IDLE;
               end
            end else begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         cnt_ff        <= '0;
         present_ff    <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         present_ff    <= present_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      op_ff         <= op_in;
      id_ff         <= id_in;
      time_ff       <= time_in;
      idx_ff        <= idx_in;
      k_ff          <= k_in;
      found_ff      <= found_in;
      pend_id_ff    <= pend_id_in;
      status_ff     <= status_in;
      rsp_id_ff     <= rsp_id_in;
      rsp_flag_ff   <= rsp_flag_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_expired_id   = rsp_id_ff;
   assign rsp_expired_flag = rsp_flag_ff;
   assign rsp_last         = rsp_last_ff;
   assign rsp_status       = rsp_status_ff;
endmodule
`default_nettype wire
